// ===== rtl/core/sebd_pkg.sv =====
// Shared types and constants of the sprite entry block decoder.
`default_nettype none

package sebd_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CODE_W = 9;
  localparam int BASE_CODE_W = 8;
  localparam int PAL_W = 4;
  localparam int POS_X_W = 17;
  localparam int POS_Y_W = 10;
  localparam int ZOOM_W = 17;
  localparam int ZSEL_W = 3;
  localparam int OFS_W = 5;

  localparam int X_BIAS = 55;
  localparam int Y_BASE = 225;
  localparam int FLIP_Y_BASE = 250;
  localparam int BLOCK_SIZE = 16;
  localparam int CODE_X_STEP = 8;
  localparam int ZOOM_FRAC_SHIFT = 13;
  // Offset of the second block is (16 - size)/2 + size, which reduces to zsel + 9.
  localparam int FAR_BLOCK_BIAS = BLOCK_SIZE / 2 + 1;

  typedef struct packed {
    logic [BASE_CODE_W-1:0] base_code;
    logic [PAL_W-1:0]       palette;
    logic                   mirror_x;
    logic                   mirror_y;
    logic                   wide;
    logic                   tall;
    logic [ZSEL_W-1:0]      zsel_x;
    logic [ZSEL_W-1:0]      zsel_y;
    logic [POS_X_W-1:0]     sx;
    logic [POS_Y_W-1:0]     sy;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } push_t;

  typedef struct packed {
    logic   empty;
    entry_t head;
  } head_t;

endpackage

`default_nettype wire

// ===== rtl/core/sebd_if.sv =====
// Channel interfaces: sprite entries in, block commands out, screen flip writes.
`default_nettype none

interface sebd_entry_if;
  logic       valid;
  logic       ready;
  logic [7:0] y_byte;
  logic [7:0] attr_byte;
  logic [7:0] tile_high_byte;
  logic [7:0] size_byte;
  logic [7:0] x_low_byte;
  logic [7:0] x_high_byte;
  logic [7:0] color_byte;

  modport source (
    output valid, y_byte, attr_byte, tile_high_byte, size_byte,
           x_low_byte, x_high_byte, color_byte,
    input  ready
  );
  modport sink (
    input  valid, y_byte, attr_byte, tile_high_byte, size_byte,
           x_low_byte, x_high_byte, color_byte,
    output ready
  );
endinterface

interface sebd_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [sebd_pkg::CODE_W-1:0]         tile_code;
  logic [sebd_pkg::PAL_W-1:0]          palette;
  logic                                mirror_x;
  logic                                mirror_y;
  logic signed [sebd_pkg::POS_X_W-1:0] pos_x;
  logic signed [sebd_pkg::POS_Y_W-1:0] pos_y;
  logic [sebd_pkg::ZOOM_W-1:0]         zoom_x;
  logic [sebd_pkg::ZOOM_W-1:0]         zoom_y;
  logic                                last_block;

  modport source (
    output valid, tile_code, palette, mirror_x, mirror_y, pos_x, pos_y,
           zoom_x, zoom_y, last_block,
    input  ready
  );
  modport sink (
    input  valid, tile_code, palette, mirror_x, mirror_y, pos_x, pos_y,
           zoom_x, zoom_y, last_block,
    output ready
  );
endinterface

interface sebd_cfg_if;
  logic valid;
  logic ready;
  logic screen_flip;

  modport source (output valid, screen_flip, input ready);
  modport sink (input valid, screen_flip, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sebd_front.sv =====
// Front end: accepts sprite entries and decodes them into queue records.
`default_nettype none

module sebd_front (
  sebd_entry_if.sink       entry,
  input  wire logic        screen_flip,
  input  wire logic        q_full,
  output sebd_pkg::push_t  push
);

  logic                             tall;
  logic [sebd_pkg::POS_Y_W-1:0]     tall_ofs;
  logic [sebd_pkg::POS_Y_W-1:0]     sy_raw;
  logic [sebd_pkg::POS_X_W-1:0]     sx_raw;

  assign entry.ready = !q_full;
  assign tall        = entry.size_byte[7];
  assign tall_ofs    = tall ? sebd_pkg::POS_Y_W'(sebd_pkg::BLOCK_SIZE) : '0;

  assign sx_raw = {1'b0, entry.x_high_byte, entry.x_low_byte}
                  - sebd_pkg::POS_X_W'(sebd_pkg::X_BIAS);
  assign sy_raw = sebd_pkg::POS_Y_W'(sebd_pkg::Y_BASE) - {2'b00, entry.y_byte} - tall_ofs;

  always_comb begin
    push.valid          = entry.valid && !q_full;
    push.data.base_code = {entry.tile_high_byte[3], entry.tile_high_byte[0],
                           entry.attr_byte[5:0]};
    push.data.palette   = entry.color_byte[7:4];
    push.data.mirror_x  = entry.attr_byte[6] ^ screen_flip;
    push.data.mirror_y  = entry.attr_byte[7] ^ screen_flip;
    push.data.wide      = entry.size_byte[3];
    push.data.tall      = tall;
    push.data.zsel_x    = entry.size_byte[2:0];
    push.data.zsel_y    = entry.size_byte[6:4];
    if (screen_flip) begin
      // Mirrored screen: x moves one block right, y reflects about the flip base.
      push.data.sx = sx_raw + sebd_pkg::POS_X_W'(sebd_pkg::BLOCK_SIZE);
      push.data.sy = sebd_pkg::POS_Y_W'(sebd_pkg::FLIP_Y_BASE) - sy_raw + tall_ofs;
    end else begin
      push.data.sx = sx_raw;
      push.data.sy = sy_raw;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sebd_queue.sv =====
// Small register queue of decoded entries between front and back end.
`default_nettype none

module sebd_queue #(
  parameter int DEPTH = sebd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sebd_pkg::push_t   push,
  input  wire logic              pop,
  output logic                   full,
  output sebd_pkg::head_t        head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sebd_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.empty = (count == '0);
  assign head.head  = slots[rd_ptr];
  assign do_pop     = pop && !head.empty;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sebd_back.sv =====
// Back end: walks the blocks of the head entry and registers one command per cycle while the output is not stalled.
`default_nettype none

module sebd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sebd_pkg::head_t head,
  output logic                 pop,
  sebd_cmd_if.source           cmd
);

  sebd_pkg::entry_t                 e;
  logic                             xb;
  logic                             ybk;
  logic                             out_free;
  logic                             issue;
  logic                             is_last;
  logic                             xo;
  logic                             yo;
  logic [sebd_pkg::OFS_W-1:0]       ox;
  logic [sebd_pkg::OFS_W-1:0]       oy;
  logic [sebd_pkg::CODE_W-1:0]      code_next;
  logic [sebd_pkg::POS_X_W-1:0]     pos_x_next;
  logic [sebd_pkg::POS_Y_W-1:0]     pos_y_next;
  logic [sebd_pkg::ZOOM_W-1:0]      zoom_x_next;
  logic [sebd_pkg::ZOOM_W-1:0]      zoom_y_next;

  logic                             valid_r;
  logic [sebd_pkg::CODE_W-1:0]      tile_code_r;
  logic [sebd_pkg::PAL_W-1:0]       palette_r;
  logic                             mirror_x_r;
  logic                             mirror_y_r;
  logic [sebd_pkg::POS_X_W-1:0]     pos_x_r;
  logic [sebd_pkg::POS_Y_W-1:0]     pos_y_r;
  logic [sebd_pkg::ZOOM_W-1:0]      zoom_x_r;
  logic [sebd_pkg::ZOOM_W-1:0]      zoom_y_r;
  logic                             last_r;

  assign e        = head.head;
  assign out_free = !valid_r || cmd.ready;
  assign issue    = out_free && !head.empty;
  assign is_last  = (xb == e.wide) && (ybk == e.tall);
  assign pop      = issue && is_last;

  // Block offsets in the code count from the far side when the entry is mirrored.
  assign xo = e.wide & (xb ^ e.mirror_x);
  assign yo = e.tall & (ybk ^ e.mirror_y);

  assign code_next = sebd_pkg::CODE_W'(e.base_code)
                     + sebd_pkg::CODE_W'(yo)
                     + (xo ? sebd_pkg::CODE_W'(sebd_pkg::CODE_X_STEP) : '0);

  // Centering offset (16 - size)/2 is 7 - zsel; the second block adds the size.
  assign ox = xb  ? sebd_pkg::OFS_W'(e.zsel_x) + sebd_pkg::OFS_W'(sebd_pkg::FAR_BLOCK_BIAS)
                  : {{(sebd_pkg::OFS_W - sebd_pkg::ZSEL_W){1'b0}}, ~e.zsel_x};
  assign oy = ybk ? sebd_pkg::OFS_W'(e.zsel_y) + sebd_pkg::OFS_W'(sebd_pkg::FAR_BLOCK_BIAS)
                  : {{(sebd_pkg::OFS_W - sebd_pkg::ZSEL_W){1'b0}}, ~e.zsel_y};

  assign pos_x_next  = e.sx + sebd_pkg::POS_X_W'(ox);
  assign pos_y_next  = e.sy + sebd_pkg::POS_Y_W'(oy);
  assign zoom_x_next = (sebd_pkg::ZOOM_W'(e.zsel_x) + 1'b1) << sebd_pkg::ZOOM_FRAC_SHIFT;
  assign zoom_y_next = (sebd_pkg::ZOOM_W'(e.zsel_y) + 1'b1) << sebd_pkg::ZOOM_FRAC_SHIFT;

  always_ff @(posedge clk) begin
    if (issue) begin
      tile_code_r <= code_next;
      palette_r   <= e.palette;
      mirror_x_r  <= e.mirror_x;
      mirror_y_r  <= e.mirror_y;
      pos_x_r     <= pos_x_next;
      pos_y_r     <= pos_y_next;
      zoom_x_r    <= zoom_x_next;
      zoom_y_r    <= zoom_y_next;
      last_r      <= is_last;
    end
    if (rst) begin
      valid_r <= 1'b0;
      xb      <= 1'b0;
      ybk     <= 1'b0;
    end else begin
      if (out_free) begin
        valid_r <= !head.empty;
      end
      if (issue) begin
        // y block is the inner loop.
        if (is_last) begin
          xb  <= 1'b0;
          ybk <= 1'b0;
        end else if (e.tall && !ybk) begin
          ybk <= 1'b1;
        end else begin
          ybk <= 1'b0;
          xb  <= 1'b1;
        end
      end
    end
  end

  assign cmd.valid      = valid_r;
  assign cmd.tile_code  = tile_code_r;
  assign cmd.palette    = palette_r;
  assign cmd.mirror_x   = mirror_x_r;
  assign cmd.mirror_y   = mirror_y_r;
  assign cmd.pos_x      = $signed(pos_x_r);
  assign cmd.pos_y      = $signed(pos_y_r);
  assign cmd.zoom_x     = zoom_x_r;
  assign cmd.zoom_y     = zoom_y_r;
  assign cmd.last_block = last_r;

endmodule

`default_nettype wire

// ===== rtl/core/sprite_entry_block_decoder_core.sv =====
// Top level of the sprite entry block decoder.
`default_nettype none

// Each accepted sprite entry yields one draw command per 16x16 block, x block
// outer and y block inner, so an entry produces 1, 2 or 4 commands and the last
// one carries last_block. The back-end sequencer issues one command per cycle into
// the output register while the output is not stalled. The front end decodes an
// entry in the cycle it is accepted and places it in a queue of QUEUE_DEPTH
// entries, so new entries are taken while the back end is still busy or the output
// is stalled, until the queue is full. screen_flip is written through cfg, which is
// always ready; change it only while no entry is in flight. An entry's first command
// passes through the queue and then the output register.
module sprite_entry_block_decoder_core #(
  parameter int QUEUE_DEPTH = sebd_pkg::QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  sebd_cfg_if.sink     cfg,
  sebd_entry_if.sink   entry,
  sebd_cmd_if.source   cmd
);

  logic             screen_flip;
  logic             q_full;
  logic             pop;
  sebd_pkg::push_t  push;
  sebd_pkg::head_t  head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_flip <= 1'b0;
    end else if (cfg.valid) begin
      screen_flip <= cfg.screen_flip;
    end
  end

  sebd_front u_front (
    .entry       (entry),
    .screen_flip (screen_flip),
    .q_full      (q_full),
    .push        (push)
  );

  sebd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  sebd_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .cmd  (cmd)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !head.empty)
    else $error("entry retired from an empty queue");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> cmd.valid && cmd.last_block)
    else $error("entry retired without issuing its last block");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !cmd.valid)
    else $error("command valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== verif/sprite_entry_block_decoder_core_test.sv =====
// Testbench for the sprite entry block decoder core: directed and random entries checked per block.
`timescale 1ns / 100ps

module sprite_entry_block_decoder_core_test;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 6;
  localparam int OUTPUT_HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 23;

  localparam int ENTRY_X_BIAS = 55;
  localparam int ENTRY_Y_BASE = 225;
  localparam int FLIPPED_Y_BASE = 250;
  localparam int BLOCK_PIX = 16;
  localparam int X_BLOCK_CODE_STEP = 8;
  localparam int ZOOM_SHIFT = 13;

  typedef struct {
    logic [7:0] y_byte;
    logic [7:0] attr_byte;
    logic [7:0] tile_high_byte;
    logic [7:0] size_byte;
    logic [7:0] x_low_byte;
    logic [7:0] x_high_byte;
    logic [7:0] color_byte;
  } sprite_entry_t;

  typedef struct {
    logic [sebd_pkg::CODE_W-1:0]         tile_code;
    logic [sebd_pkg::PAL_W-1:0]          palette;
    logic                                mirror_x;
    logic                                mirror_y;
    logic signed [sebd_pkg::POS_X_W-1:0] pos_x;
    logic signed [sebd_pkg::POS_Y_W-1:0] pos_y;
    logic [sebd_pkg::ZOOM_W-1:0]         zoom_x;
    logic [sebd_pkg::ZOOM_W-1:0]         zoom_y;
    logic                                last_block;
  } block_cmd_t;

  logic clk;
  logic rst;

  sebd_cfg_if   cfg_ch ();
  sebd_entry_if entry_ch ();
  sebd_cmd_if   cmd_ch ();

  sprite_entry_block_decoder_core dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .entry (entry_ch),
    .cmd   (cmd_ch)
  );

  block_cmd_t pending_cmds[$];
  bit         flip_setting;
  int         mismatches;
  bit         tx_idle_on;
  bit         rx_idle_on;
  int         rx_hold;
  int         rx_stall_left;
  int         quiet_cycles;
  block_cmd_t got_cmd;
  block_cmd_t want_cmd;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly no gap or a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic sprite_entry_t mk_entry(input logic [7:0] y, attr, th, sz, xl, xh, col);
    sprite_entry_t e;
    e.y_byte = y;
    e.attr_byte = attr;
    e.tile_high_byte = th;
    e.size_byte = sz;
    e.x_low_byte = xl;
    e.x_high_byte = xh;
    e.color_byte = col;
    return e;
  endfunction

  function automatic sprite_entry_t rand_entry();
    return mk_entry(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
  endfunction

  // Expands one entry into its block commands, x block outer and y block inner.
  function automatic void expand_entry_blocks(input sprite_entry_t e);
    block_cmd_t c;
    bit fx, fy;
    int cols, rows, sx, sy, zx, zy, xpix, ypix, ox, oy, xo, yo, base;
    fy = e.attr_byte[7];
    fx = e.attr_byte[6];
    cols = e.size_byte[3] ? 2 : 1;
    rows = e.size_byte[7] ? 2 : 1;
    base = int'({e.tile_high_byte[3], e.tile_high_byte[0], e.attr_byte[5:0]});
    sx = int'({e.x_high_byte, e.x_low_byte}) - ENTRY_X_BIAS;
    sy = ENTRY_Y_BASE - int'(e.y_byte);
    zx = (int'(e.size_byte[2:0]) + 1) << ZOOM_SHIFT;
    zy = (int'(e.size_byte[6:4]) + 1) << ZOOM_SHIFT;
    xpix = (zx * BLOCK_PIX) >> 16;
    ypix = (zy * BLOCK_PIX) >> 16;
    if (rows == 2) sy -= BLOCK_PIX;
    if (flip_setting) begin
      fx = !fx;
      fy = !fy;
      sx += BLOCK_PIX;
      sy = FLIPPED_Y_BASE - sy;
      if (rows == 2) sy += BLOCK_PIX;
    end
    for (int xb = 0; xb < cols; xb++) begin
      xo = fx ? (cols - xb - 1) : xb;
      for (int yb = 0; yb < rows; yb++) begin
        yo = fy ? (rows - yb - 1) : yb;
        ox = (BLOCK_PIX - xpix) / 2 + (xb != 0 ? xpix : 0);
        oy = (BLOCK_PIX - ypix) / 2 + (yb != 0 ? ypix : 0);
        c.tile_code = sebd_pkg::CODE_W'(base + yo + xo * X_BLOCK_CODE_STEP);
        c.palette = e.color_byte[7:4];
        c.mirror_x = fx;
        c.mirror_y = fy;
        c.pos_x = sebd_pkg::POS_X_W'(sx + ox);
        c.pos_y = sebd_pkg::POS_Y_W'(sy + oy);
        c.zoom_x = sebd_pkg::ZOOM_W'(zx);
        c.zoom_y = sebd_pkg::ZOOM_W'(zy);
        c.last_block = (xb == cols - 1) && (yb == rows - 1);
        pending_cmds.push_back(c);
      end
    end
  endfunction

  // Entered and left at a falling edge; valid stays high when the call returns.
  task automatic send_entry(input sprite_entry_t e);
    int gap;
    gap = tx_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      entry_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    entry_ch.valid <= 1'b1;
    entry_ch.y_byte <= e.y_byte;
    entry_ch.attr_byte <= e.attr_byte;
    entry_ch.tile_high_byte <= e.tile_high_byte;
    entry_ch.size_byte <= e.size_byte;
    entry_ch.x_low_byte <= e.x_low_byte;
    entry_ch.x_high_byte <= e.x_high_byte;
    entry_ch.color_byte <= e.color_byte;
    do @(posedge clk); while (!entry_ch.ready);
    expand_entry_blocks(e);
    @(negedge clk);
  endtask

  task automatic drain_commands();
    entry_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_screen_flip(input bit value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.screen_flip <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    flip_setting = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_corner_entries();
    send_entry(mk_entry(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_entry(mk_entry(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_entry(mk_entry(8'h0a, 8'h15, 8'h01, 8'h0f, 8'h34, 8'h12, 8'h50));
    send_entry(mk_entry(8'h40, 8'h80, 8'h08, 8'hf0, 8'h99, 8'h00, 8'hf0));
    send_entry(mk_entry(8'h80, 8'h7f, 8'h08, 8'h88, 8'h10, 8'h01, 8'h0f));
    send_entry(mk_entry(8'hc3, 8'h80, 8'h09, 8'hbb, 8'h00, 8'h80, 8'ha5));
    send_entry(mk_entry(8'h20, 8'h2a, 8'h00, 8'hcc, 8'h37, 8'h00, 8'h30));
    send_entry(mk_entry(8'h00, 8'h40, 8'hf6, 8'h35, 8'hff, 8'hff, 8'h00));
  endtask

  task automatic test_directed();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_screen_flip(1'b0);
    send_corner_entries();
    send_entry(mk_entry(8'hff, 8'h3f, 8'h00, 8'h77, 8'h00, 8'h00, 8'h10));
    send_entry(mk_entry(8'h7f, 8'hc0, 8'h06, 8'h4a, 8'h5a, 8'h7e, 8'he0));
    drain_commands();
  endtask

  // With the screen flipped, flips invert and positions mirror.
  task automatic test_screen_flip();
    write_screen_flip(1'b1);
    send_corner_entries();
    drain_commands();
    write_screen_flip(1'b0);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 4; p++) begin
      write_screen_flip(p[0]);
      tx_idle_on = (p != 1) && (p != 2);
      rx_idle_on = (p != 1) && (p != 3);
      repeat (PHASE_ITEMS) send_entry(rand_entry());
      drain_commands();
    end
  endtask

  // The output is held off long enough for the block to fill and stall its input.
  task automatic test_output_hold();
    write_screen_flip(1'b1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    rx_hold = OUTPUT_HOLD_CYCLES;
    repeat (12) send_entry(rand_entry());
    drain_commands();
  endtask

  initial begin
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.screen_flip = 1'b0;
    entry_ch.valid = 1'b0;
    entry_ch.y_byte = '0;
    entry_ch.attr_byte = '0;
    entry_ch.tile_high_byte = '0;
    entry_ch.size_byte = '0;
    entry_ch.x_low_byte = '0;
    entry_ch.x_high_byte = '0;
    entry_ch.color_byte = '0;
    flip_setting = 1'b0;
    mismatches = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_screen_flip();
    test_random_phases();
    test_output_hold();
    drain_commands();
    if (mismatches == 0) begin
      $display("PASS sprite_entry_block_decoder_core");
    end else begin
      $display("FAIL sprite_entry_block_decoder_core");
    end
    $finish;
  end

  // Command sink: a requested hold-off takes priority over random stalls.
  initial begin
    cmd_ch.ready = 1'b0;
    rx_stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        cmd_ch.ready <= 1'b0;
        rx_hold--;
      end else if (rx_stall_left > 0) begin
        cmd_ch.ready <= 1'b0;
        rx_stall_left--;
      end else begin
        cmd_ch.ready <= 1'b1;
        if (rx_idle_on) rx_stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      got_cmd.tile_code = cmd_ch.tile_code;
      got_cmd.palette = cmd_ch.palette;
      got_cmd.mirror_x = cmd_ch.mirror_x;
      got_cmd.mirror_y = cmd_ch.mirror_y;
      got_cmd.pos_x = cmd_ch.pos_x;
      got_cmd.pos_y = cmd_ch.pos_y;
      got_cmd.zoom_x = cmd_ch.zoom_x;
      got_cmd.zoom_y = cmd_ch.zoom_y;
      got_cmd.last_block = cmd_ch.last_block;
      if (pending_cmds.size() == 0) begin
        $error("block command with none expected: tile_code %0d", got_cmd.tile_code);
        mismatches++;
      end else begin
        want_cmd = pending_cmds.pop_front();
        if (got_cmd.tile_code !== want_cmd.tile_code) begin
          $error("tile_code: expected %0d, got %0d", want_cmd.tile_code, got_cmd.tile_code);
          mismatches++;
        end
        if (got_cmd.palette !== want_cmd.palette) begin
          $error("palette: expected %0d, got %0d", want_cmd.palette, got_cmd.palette);
          mismatches++;
        end
        if (got_cmd.mirror_x !== want_cmd.mirror_x) begin
          $error("mirror_x: expected %0b, got %0b", want_cmd.mirror_x, got_cmd.mirror_x);
          mismatches++;
        end
        if (got_cmd.mirror_y !== want_cmd.mirror_y) begin
          $error("mirror_y: expected %0b, got %0b", want_cmd.mirror_y, got_cmd.mirror_y);
          mismatches++;
        end
        if (got_cmd.pos_x !== want_cmd.pos_x) begin
          $error("pos_x: expected %0d, got %0d", want_cmd.pos_x, got_cmd.pos_x);
          mismatches++;
        end
        if (got_cmd.pos_y !== want_cmd.pos_y) begin
          $error("pos_y: expected %0d, got %0d", want_cmd.pos_y, got_cmd.pos_y);
          mismatches++;
        end
        if (got_cmd.zoom_x !== want_cmd.zoom_x) begin
          $error("zoom_x: expected %0d, got %0d", want_cmd.zoom_x, got_cmd.zoom_x);
          mismatches++;
        end
        if (got_cmd.zoom_y !== want_cmd.zoom_y) begin
          $error("zoom_y: expected %0d, got %0d", want_cmd.zoom_y, got_cmd.zoom_y);
          mismatches++;
        end
        if (got_cmd.last_block !== want_cmd.last_block) begin
          $error("last_block: expected %0b, got %0b", want_cmd.last_block,
                 got_cmd.last_block);
          mismatches++;
        end
      end
    end
  end

  // Ends the run when no channel has moved an item for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((entry_ch.valid && entry_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL sprite_entry_block_decoder_core");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/sebd_pkg.sv
rtl/core/sebd_if.sv
rtl/core/sebd_front.sv
rtl/core/sebd_queue.sv
rtl/core/sebd_back.sv
rtl/core/sprite_entry_block_decoder_core.sv
verif/sprite_entry_block_decoder_core_test.sv
